### rtl/bmhq_pkg.sv
// ----------------------------------------------------------------------------
// bmhq_pkg
// shared types, codes and defaults for the binary min-heap priority queue
// ----------------------------------------------------------------------------
package bmhq_pkg;

    // port field widths
    localparam int KEY_PORT_W     = 32;
    localparam int PAYLOAD_PORT_W = 16;
    localparam int STATUS_W       = 2;
    localparam int COUNT_PORT_W   = 7;

    // parameter defaults
    localparam int DEF_CAPACITY      = 64;
    localparam int DEF_KEY_WIDTH     = 32;
    localparam int DEF_PAYLOAD_WIDTH = 16;

    // request opcodes
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic                      cmd;
        logic [KEY_PORT_W-1:0]     key;
        logic [PAYLOAD_PORT_W-1:0] payload;
    } req_t;

    typedef struct packed {
        logic                      out_valid;
        logic [KEY_PORT_W-1:0]     out_key;
        logic [PAYLOAD_PORT_W-1:0] out_payload;
        logic [STATUS_W-1:0]       out_status;
        logic [COUNT_PORT_W-1:0]   out_count;
        logic [KEY_PORT_W-1:0]     top_key;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP_CHECK,
        ST_UP_STEP,
        ST_POP_READ,
        ST_POP_LOAD,
        ST_DOWN_STEP,
        ST_FINISH
    } state_t;

    // per-cycle datapath command
    typedef enum logic [2:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_UP_CHECK,
        OP_UP_STEP,
        OP_POP_READ,
        OP_POP_LOAD,
        OP_DOWN_STEP,
        OP_FINISH
    } dp_op_t;

    // datapath status back to the controller
    typedef struct packed {
        logic req_pop;
        logic req_fault;
        logic hole_root;
        logic up_less;
        logic parent_root;
        logic drained;
        logic down_less;
        logic out_free;
    } dp_status_t;

endpackage

### rtl/binary_min_heap_queue.sv
// ----------------------------------------------------------------------------
// binary_min_heap_queue
// min-heap priority queue of key and payload entries with push and pop
// ----------------------------------------------------------------------------
// Each request is a push (append, then sift up while strictly smaller than the
// parent) or a pop (return the root, move the last entry to the root, then
// sift down toward the smaller child, left on a tie). Every request gives one
// result carrying the popped entry, a status (ok, pop on empty, push on full),
// the count after the operation and the key now at the root. Requests are
// handled one at a time. Each level that a push climbs or a pop descends
// costs one read-compare-write step, since the heap memory gives two reads
// and one write per cycle; a push into an empty queue writes the root
// directly, and a pop that takes the last entry does no sift. The result
// state holds while the result register waits on m_ready. A new request is
// taken while the previous result still waits in the output register. The
// heap memory needs no clearing after reset; only slots below the count are
// ever used.
// ----------------------------------------------------------------------------
module binary_min_heap_queue #(
    parameter int CAPACITY      = bmhq_pkg::DEF_CAPACITY,
    parameter int KEY_WIDTH     = bmhq_pkg::DEF_KEY_WIDTH,
    parameter int PAYLOAD_WIDTH = bmhq_pkg::DEF_PAYLOAD_WIDTH
) (
    input  logic            aclk,
    input  logic            aresetn,

    // request channel
    input  logic            s_valid,
    output logic            s_ready,
    input  bmhq_pkg::req_t  s_data,

    // result channel
    output logic            m_valid,
    input  logic            m_ready,
    output bmhq_pkg::rsp_t  m_data
);
    import bmhq_pkg::*;

    // command from the sequencer, status back from the datapath
    dp_op_t     dp_op;
    dp_status_t dp_status;

    // sequencer: idle, sift-up steps, pop fetch, sift-down steps, result
    bmhq_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .dp_status (dp_status),
        .dp_op     (dp_op)
    );

    // heap memory, hole and moving entry, count, root key, result register
    bmhq_dp #(
        .CAPACITY      (CAPACITY),
        .KEY_WIDTH     (KEY_WIDTH),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .dp_op     (dp_op),
        .dp_status (dp_status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

### rtl/bmhq_ctrl.sv
// ----------------------------------------------------------------------------
// bmhq_ctrl
// sequencer for push sift-up and pop sift-down, one heap level per step
// ----------------------------------------------------------------------------
module bmhq_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  bmhq_pkg::dp_status_t  dp_status,
    output bmhq_pkg::dp_op_t      dp_op
);
    import bmhq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (dp_status.req_fault) begin
                        state_next = ST_FINISH;
                    end else if (dp_status.req_pop) begin
                        state_next = ST_POP_READ;
                    end else begin
                        state_next = ST_UP_CHECK;
                    end
                end
            end
            ST_UP_CHECK: begin
                state_next = dp_status.hole_root ? ST_FINISH : ST_UP_STEP;
            end
            ST_UP_STEP: begin
                if (!dp_status.up_less) begin
                    state_next = ST_FINISH;
                end else if (dp_status.parent_root) begin
                    state_next = ST_UP_CHECK;
                end
            end
            ST_POP_READ: begin
                state_next = ST_POP_LOAD;
            end
            ST_POP_LOAD: begin
                state_next = dp_status.drained ? ST_FINISH : ST_DOWN_STEP;
            end
            ST_DOWN_STEP: begin
                if (!dp_status.down_less) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (dp_status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        s_ready = 1'b0;
        dp_op   = OP_NOP;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                dp_op   = s_valid ? OP_ACCEPT : OP_NOP;
            end
            ST_UP_CHECK:  dp_op = OP_UP_CHECK;
            ST_UP_STEP:   dp_op = OP_UP_STEP;
            ST_POP_READ:  dp_op = OP_POP_READ;
            ST_POP_LOAD:  dp_op = OP_POP_LOAD;
            ST_DOWN_STEP: dp_op = OP_DOWN_STEP;
            ST_FINISH:    dp_op = dp_status.out_free ? OP_FINISH : OP_NOP;
            default:      dp_op = OP_NOP;
        endcase
    end

endmodule

### rtl/bmhq_dp.sv
// ----------------------------------------------------------------------------
// bmhq_dp
// heap memory, moving-entry register, hole index, count and result register
// ----------------------------------------------------------------------------
module bmhq_dp #(
    parameter int CAPACITY      = bmhq_pkg::DEF_CAPACITY,
    parameter int KEY_WIDTH     = bmhq_pkg::DEF_KEY_WIDTH,
    parameter int PAYLOAD_WIDTH = bmhq_pkg::DEF_PAYLOAD_WIDTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  bmhq_pkg::req_t        s_data,
    input  bmhq_pkg::dp_op_t      dp_op,
    output bmhq_pkg::dp_status_t  dp_status,
    output logic                  m_valid,
    input  logic                  m_ready,
    output bmhq_pkg::rsp_t        m_data
);
    import bmhq_pkg::*;

    localparam int AW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int LW  = AW + 2;
    localparam int EW  = KEY_WIDTH + PAYLOAD_WIDTH;
    localparam int KIN = (KEY_WIDTH < KEY_PORT_W) ? KEY_WIDTH : KEY_PORT_W;
    localparam int PIN = (PAYLOAD_WIDTH < PAYLOAD_PORT_W) ? PAYLOAD_WIDTH : PAYLOAD_PORT_W;

    // heap storage, key in the upper bits
    logic [EW-1:0] heap_mem [CAPACITY];

    logic [AW-1:0]            wr_addr;
    logic [EW-1:0]            wr_data;
    logic                     wr_en;
    logic [AW-1:0]            rd_a_addr;
    logic [AW-1:0]            rd_b_addr;
    logic [EW-1:0]            rd_a_reg;
    logic [EW-1:0]            rd_b_reg;

    logic [KEY_WIDTH-1:0]     entry_key_reg,  entry_key_next;
    logic [PAYLOAD_WIDTH-1:0] entry_pay_reg,  entry_pay_next;
    logic [AW-1:0]            hole_reg,       hole_next;
    logic [CW-1:0]            count_reg,      count_next;
    logic [STATUS_W-1:0]      status_reg,     status_next;
    logic                     pop_ok_reg,     pop_ok_next;
    logic [KEY_WIDTH-1:0]     pop_key_reg,    pop_key_next;
    logic [PAYLOAD_WIDTH-1:0] pop_pay_reg,    pop_pay_next;
    logic [KEY_WIDTH-1:0]     root_key_reg,   root_key_next;
    logic                     m_valid_reg,    m_valid_next;
    rsp_t                     m_data_reg,     m_data_next;

    logic [KEY_WIDTH-1:0]     key_a;
    logic [KEY_WIDTH-1:0]     key_b;
    logic [AW-1:0]            parent_idx;
    logic [AW-1:0]            grand_idx;
    logic [LW-1:0]            left_idx;
    logic [LW-1:0]            right_idx;
    logic [LW-1:0]            count_ext;
    logic                     pick_right;
    logic [AW-1:0]            child_idx;
    logic [EW-1:0]            child_entry;
    logic                     up_less;
    logic                     down_less;
    logic                     req_fault;
    logic                     out_free;

    assign key_a      = rd_a_reg[EW-1 -: KEY_WIDTH];
    assign key_b      = rd_b_reg[EW-1 -: KEY_WIDTH];
    assign parent_idx = AW'((hole_reg - AW'(1)) >> 1);
    assign grand_idx  = AW'((parent_idx - AW'(1)) >> 1);

    // children of the hole, wide enough to compare against the count
    assign left_idx   = LW'({hole_reg, 1'b1});
    assign right_idx  = left_idx + LW'(1);
    assign count_ext  = LW'(count_reg);
    assign pick_right = (right_idx < count_ext) && (key_b < key_a);
    assign child_idx  = pick_right ? AW'(right_idx) : AW'(left_idx);
    assign child_entry = pick_right ? rd_b_reg : rd_a_reg;

    assign up_less   = entry_key_reg < key_a;
    assign down_less = (left_idx < count_ext)
                     && (child_entry[EW-1 -: KEY_WIDTH] < entry_key_reg);
    assign req_fault = (s_data.cmd == CMD_POP) ? (count_reg == '0)
                                               : (count_reg >= CW'(CAPACITY));
    assign out_free  = !m_valid_reg || m_ready;

    always_comb begin
        dp_status.req_pop     = (s_data.cmd == CMD_POP);
        dp_status.req_fault   = req_fault;
        dp_status.hole_root   = (hole_reg == '0);
        dp_status.up_less     = up_less;
        dp_status.parent_root = (parent_idx == '0);
        dp_status.drained     = (count_reg == '0);
        dp_status.down_less   = down_less;
        dp_status.out_free    = out_free;
    end

    always_comb begin
        entry_key_next = entry_key_reg;
        entry_pay_next = entry_pay_reg;
        hole_next      = hole_reg;
        count_next     = count_reg;
        status_next    = status_reg;
        pop_ok_next    = pop_ok_reg;
        pop_key_next   = pop_key_reg;
        pop_pay_next   = pop_pay_reg;
        root_key_next  = root_key_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        wr_en          = 1'b0;
        wr_addr        = hole_reg;
        wr_data        = {entry_key_reg, entry_pay_reg};
        rd_a_addr      = parent_idx;
        rd_b_addr      = parent_idx;

        case (dp_op)
            OP_ACCEPT: begin
                entry_key_next = KEY_WIDTH'(s_data.key[KIN-1:0]);
                entry_pay_next = PAYLOAD_WIDTH'(s_data.payload[PIN-1:0]);
                pop_ok_next    = 1'b0;
                status_next    = STATUS_OK;
                if (req_fault) begin
                    status_next = (s_data.cmd == CMD_POP) ? STATUS_EMPTY : STATUS_FULL;
                end else if (s_data.cmd == CMD_PUSH) begin
                    hole_next  = AW'(count_reg);
                    count_next = count_reg + CW'(1);
                end
            end
            OP_UP_CHECK: begin
                // at the root the new entry lands, otherwise fetch the parent
                if (hole_reg == '0) begin
                    wr_en         = 1'b1;
                    root_key_next = entry_key_reg;
                end
            end
            OP_UP_STEP: begin
                wr_en = 1'b1;
                if (up_less) begin
                    wr_data   = rd_a_reg;
                    hole_next = parent_idx;
                    rd_a_addr = grand_idx;
                end
            end
            OP_POP_READ: begin
                rd_a_addr  = '0;
                rd_b_addr  = AW'(count_reg - CW'(1));
                count_next = count_reg - CW'(1);
            end
            OP_POP_LOAD: begin
                pop_ok_next    = 1'b1;
                pop_key_next   = key_a;
                pop_pay_next   = rd_a_reg[PAYLOAD_WIDTH-1:0];
                entry_key_next = key_b;
                entry_pay_next = rd_b_reg[PAYLOAD_WIDTH-1:0];
                hole_next      = '0;
                rd_a_addr      = AW'(1);
                rd_b_addr      = AW'(2);
            end
            OP_DOWN_STEP: begin
                wr_en = 1'b1;
                if (down_less) begin
                    wr_data   = child_entry;
                    hole_next = child_idx;
                    rd_a_addr = AW'({child_idx, 1'b1});
                    rd_b_addr = AW'({child_idx, 1'b1}) + AW'(1);
                    if (hole_reg == '0) begin
                        root_key_next = child_entry[EW-1 -: KEY_WIDTH];
                    end
                end else if (hole_reg == '0) begin
                    root_key_next = entry_key_reg;
                end
            end
            OP_FINISH: begin
                m_valid_next           = 1'b1;
                m_data_next.out_valid  = pop_ok_reg;
                m_data_next.out_key    = pop_ok_reg ? KEY_PORT_W'(pop_key_reg) : '0;
                m_data_next.out_payload =
                    pop_ok_reg ? PAYLOAD_PORT_W'(pop_pay_reg) : '0;
                m_data_next.out_status = status_reg;
                m_data_next.out_count  = COUNT_PORT_W'(count_reg);
                m_data_next.top_key    =
                    (count_reg == '0) ? '0 : KEY_PORT_W'(root_key_reg);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            heap_mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= heap_mem[rd_a_addr];
        rd_b_reg <= heap_mem[rd_b_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        entry_key_reg <= entry_key_next;
        entry_pay_reg <= entry_pay_next;
        hole_reg      <= hole_next;
        status_reg    <= status_next;
        pop_ok_reg    <= pop_ok_next;
        pop_key_reg   <= pop_key_next;
        pop_pay_reg   <= pop_pay_next;
        root_key_reg  <= root_key_next;
        m_data_reg    <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // count stays within the store
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("entry count beyond capacity");

    // the hole always sits on an occupied slot while sifting
    assert property (@(posedge aclk) disable iff (!aresetn)
        (dp_op == OP_UP_CHECK || dp_op == OP_UP_STEP || dp_op == OP_DOWN_STEP)
        |-> (CW'(hole_reg) < count_reg))
        else $error("sift hole outside occupied slots");

    // a popped key never exceeds the new root
    assert property (@(posedge aclk) disable iff (!aresetn)
        (dp_op == OP_FINISH && pop_ok_reg && count_reg != '0)
        |-> (pop_key_reg <= root_key_reg))
        else $error("heap order broken after pop");

    // an entry is returned only on a clean pop
    assert property (@(posedge aclk) disable iff (!aresetn)
        (dp_op == OP_FINISH) |=> (m_valid_reg
            && (!m_data_reg.out_valid || m_data_reg.out_status == STATUS_OK)))
        else $error("result flagged both returned and faulted");

endmodule
